// ----- rtl/core/dlt_pkg.sv -----
// Shared types and constants for the debug log device tracker.
package dlt_pkg;

    // Byte codes seen in the log text
    localparam logic [7:0] ESC_BYTE   = 8'h1b;
    localparam logic [7:0] CLOSE_BYTE = 8'h29;
    localparam logic [7:0] TAG_ERROR  = 8'h45;
    localparam logic [7:0] TAG_WARN   = 8'h57;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;

    // Tag position when the packet opens with an escape byte
    localparam logic [2:0] ESC_TAG_OFFSET = 3'd7;
    // Digits start this many bytes after the tag
    localparam logic [7:0] DIGIT_GAP = 8'd3;
    localparam logic [7:0] POS_MAX = 8'd255;

    // Configuration
    localparam logic [31:0] STEP_RESET = 32'd10000;
    localparam logic        REG_STEP   = 1'b0;

    // Table size
    localparam int MAX_DEVICES_DEF = 32;
    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hffff;

    // Event queue depth
    localparam int EVQ_DEPTH = 4;

    // Event kinds
    localparam logic [2:0] KIND_ERROR   = 3'd0;
    localparam logic [2:0] KIND_WARN    = 3'd1;
    localparam logic [2:0] KIND_COUNT   = 3'd2;
    localparam logic [2:0] KIND_REBOOT  = 3'd3;
    localparam logic [2:0] KIND_NETTIME = 3'd4;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_TAG,
        PH_RUN,
        PH_SKIP
    } phase_t;

    // Search request that walks down the device cells
    typedef struct packed {
        logic        valid;
        logic        found;
        logic        is_new;
        logic        reboot;
        logic [47:0] mac;
        logic [31:0] rt;
    } query_t;

    // Error or warning tag seen on the current byte
    typedef struct packed {
        logic       valid;
        logic [2:0] kind;
    } tag_ev_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] value;
        logic        last;
    } event_t;

    // Up to two events written into the queue in one cycle
    typedef struct packed {
        logic   valid0;
        event_t ev0;
        logic   valid1;
        event_t ev1;
    } push_t;

endpackage

// ----- rtl/core/dlt_parser.sv -----
// Byte parser: finds the tag and accumulates the runtime digits of a packet.
module dlt_parser (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [47:0]     source_mac,
    input  logic [7:0]      data_byte,
    input  logic            last_byte,
    output dlt_pkg::tag_ev_t tag_ev,
    output dlt_pkg::query_t  fin
);
    import dlt_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  pos_reg, pos_next;
    logic [2:0]  off_reg, off_next;
    logic [31:0] accum_reg, accum_next;
    logic        do_tag;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            pos_reg   <= '0;
            off_reg   <= '0;
            accum_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            off_reg   <= off_next;
            accum_reg <= accum_next;
        end
    end

    // Next state and tag / finish outputs
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        off_next   = off_reg;
        accum_next = accum_reg;
        do_tag     = 1'b0;
        tag_ev     = '0;
        fin        = '0;
        fin.mac    = source_mac;
        fin.rt     = accum_reg;

        if (accept)
        begin
            unique case (phase_reg)
                PH_FIRST:
                begin
                    if (data_byte == ESC_BYTE)
                    begin
                        off_next   = ESC_TAG_OFFSET;
                        phase_next = PH_TAG;
                    end
                    else
                    begin
                        off_next = '0;
                        do_tag   = 1'b1;
                    end
                end
                PH_TAG:
                begin
                    do_tag = (pos_reg == {5'd0, off_reg});
                end
                PH_RUN:
                begin
                    if (pos_reg >= ({5'd0, off_reg} + DIGIT_GAP))
                    begin
                        if (data_byte == CLOSE_BYTE)
                        begin
                            fin.valid  = 1'b1;
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            // runtime*10 + b - '0', wrapping at 32 bits
                            accum_next = (accum_reg << 3) + (accum_reg << 1)
                                       + {24'd0, data_byte} - {24'd0, DIGIT_ZERO};
                        end
                    end
                end
                PH_SKIP:
                begin
                    phase_next = PH_SKIP;
                end
                default:
                begin
                    phase_next = PH_FIRST;
                end
            endcase

            // Tag decode
            if (do_tag)
            begin
                if (data_byte == TAG_ERROR)
                begin
                    tag_ev.valid = 1'b1;
                    tag_ev.kind  = KIND_ERROR;
                    phase_next   = PH_SKIP;
                end
                else if (data_byte == TAG_WARN)
                begin
                    tag_ev.valid = 1'b1;
                    tag_ev.kind  = KIND_WARN;
                    phase_next   = PH_SKIP;
                end
                else
                begin
                    phase_next = PH_RUN;
                end
            end

            if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + 8'd1;
            end

            // Packet end restarts parsing
            if (last_byte)
            begin
                pos_next   = '0;
                off_next   = '0;
                phase_next = PH_FIRST;
                accum_next = '0;
            end
        end
    end

endmodule

// ----- rtl/core/dlt_cell.sv -----
// One device slot: compares a passing search request and updates its entry.
module dlt_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  dlt_pkg::query_t q_in,
    output dlt_pkg::query_t q_out
);
    import dlt_pkg::*;

    logic [47:0] addr_reg, addr_next;
    logic [31:0] rt_reg, rt_next;
    query_t      q_reg, q_next;

    assign q_out = q_reg;

    // Address and request stage; zero address marks an empty slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
            q_reg    <= '0;
        end
        else
        begin
            addr_reg <= addr_next;
            q_reg    <= q_next;
        end
    end

    // Runtime is only read from an occupied slot
    always_ff @(posedge clk)
    begin
        rt_reg <= rt_next;
    end

    // Slot match / claim
    always_comb
    begin
        q_next    = q_in;
        addr_next = addr_reg;
        rt_next   = rt_reg;
        if (q_in.valid && !q_in.found)
        begin
            if (addr_reg == '0)
            begin
                addr_next     = q_in.mac;
                rt_next       = q_in.rt;
                q_next.found  = 1'b1;
                q_next.is_new = 1'b1;
            end
            else if (addr_reg == q_in.mac)
            begin
                q_next.found = 1'b1;
                if (rt_reg > q_in.rt)
                begin
                    q_next.reboot = 1'b1;
                    rt_next       = '0;
                end
                else
                begin
                    rt_next = q_in.rt;
                end
            end
        end
    end

endmodule

// ----- rtl/core/dlt_evq.sv -----
// Small event queue that holds results until the output side takes them.
module dlt_evq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dlt_pkg::push_t       push,
    output logic [$clog2(dlt_pkg::EVQ_DEPTH):0] count,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,
    output logic [2:0]           m_tuser,
    output logic                 m_tlast
);
    import dlt_pkg::*;

    localparam int PW = $clog2(EVQ_DEPTH);

    event_t        ev_reg [EVQ_DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [PW:0]   cnt_reg, cnt_next;
    logic [PW-1:0] wr_second;
    logic          pop;

    assign count     = cnt_reg;
    assign m_tvalid  = (cnt_reg != '0);
    assign m_tdata   = ev_reg[rd_reg].value;
    assign m_tuser   = ev_reg[rd_reg].kind;
    assign m_tlast   = ev_reg[rd_reg].last;
    assign pop       = m_tvalid && m_tready;
    assign wr_second = wr_reg + PW'(1);

    // Pointer and count update
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push.valid0)
        begin
            wr_next  = wr_next + PW'(1);
            cnt_next = cnt_next + (PW+1)'(1);
        end
        if (push.valid1)
        begin
            wr_next  = wr_next + PW'(1);
            cnt_next = cnt_next + (PW+1)'(1);
        end
        if (pop)
        begin
            rd_next  = rd_reg + PW'(1);
            cnt_next = cnt_next - (PW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Entry storage; the second event follows the first
    always_ff @(posedge clk)
    begin
        if (push.valid0)
        begin
            ev_reg[wr_reg] <= push.ev0;
        end
        if (push.valid1)
        begin
            ev_reg[wr_second] <= push.ev1;
        end
    end

endmodule

// ----- rtl/core/debug_log_device_tracker.sv -----
// Debug log device tracker top level: parser, device cell chain, event queue, APB register.
// An error/warning tag event enters the event queue in the same cycle its byte is taken; the
//   events of a ')' byte enter it once the search has walked the chain of device cell registers.
// One byte per cycle is taken while s_tready is high; a ')' byte holds s_tready low until its
//   search, which passes one device cell per cycle, is done; the event queue keeps room for two events.
// Reset: all device addresses, counters and the parser clear at once; runtime_step reads 10000.
module debug_log_device_tracker #(
    parameter int MAX_DEVICES = dlt_pkg::MAX_DEVICES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata: source_mac [47:0], data_byte [55:48]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic        s_tlast,
    // m_tdata: event_value [31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    // m_tuser: event_kind [2:0]
    output logic [2:0]  m_tuser,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dlt_pkg::*;

    localparam int QCW = $clog2(EVQ_DEPTH) + 1;

    logic [31:0]        step_reg;
    logic [31:0]        shown_reg, shown_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               busy_reg, busy_next;
    logic               accept;
    logic               net_hit;
    logic [QCW-1:0]     q_count;
    tag_ev_t            tag_ev;
    query_t             q_chain [MAX_DEVICES+1];
    query_t             done_q;
    push_t              push;

    assign pready   = 1'b1;
    assign s_tready = !busy_reg && (q_count <= QCW'(EVQ_DEPTH - 2));
    assign accept   = s_tvalid && s_tready;
    assign prdata   = (paddr[2] == REG_STEP) ? step_reg : 32'd0;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_STEP))
        begin
            step_reg <= pwdata;
        end
    end

    dlt_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .source_mac (s_tdata[47:0]),
        .data_byte  (s_tdata[55:48]),
        .last_byte  (s_tlast),
        .tag_ev     (tag_ev),
        .fin        (q_chain[0])
    );

    // Device slots, one per cell; the search moves one cell per cycle
    for (genvar i = 0; i < MAX_DEVICES; i++)
    begin : g_cell
        dlt_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .q_in  (q_chain[i]),
            .q_out (q_chain[i+1])
        );
    end

    assign done_q  = q_chain[MAX_DEVICES];
    assign net_hit = done_q.rt > (shown_reg + step_reg);

    // Search bookkeeping and event assembly
    always_comb
    begin
        busy_next  = busy_reg;
        shown_next = shown_reg;
        count_next = count_reg;
        push       = '0;

        if (q_chain[0].valid)
        begin
            busy_next = 1'b1;
        end

        if (done_q.valid)
        begin
            busy_next = 1'b0;
            if (done_q.is_new && (count_reg != COUNT_MAX))
            begin
                count_next = count_reg + COUNT_W'(1);
            end
            if (net_hit)
            begin
                shown_next = done_q.rt;
            end

            if (done_q.is_new || done_q.reboot)
            begin
                push.valid0     = 1'b1;
                push.ev0.kind   = done_q.is_new ? KIND_COUNT : KIND_REBOOT;
                push.ev0.value  = done_q.is_new ? 32'(count_next) : 32'd0;
                push.ev0.last   = !net_hit;
                push.valid1     = net_hit;
                push.ev1.kind   = KIND_NETTIME;
                push.ev1.value  = done_q.rt;
                push.ev1.last   = 1'b1;
            end
            else if (net_hit)
            begin
                push.valid0    = 1'b1;
                push.ev0.kind  = KIND_NETTIME;
                push.ev0.value = done_q.rt;
                push.ev0.last  = 1'b1;
            end
        end
        else if (tag_ev.valid)
        begin
            push.valid0    = 1'b1;
            push.ev0.kind  = tag_ev.kind;
            push.ev0.value = 32'd0;
            push.ev0.last  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            shown_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            shown_reg <= shown_next;
            count_reg <= count_next;
        end
    end

    dlt_evq u_evq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .count    (q_count),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- rtl/core/dlt_checker.sv -----
// Port-level checks for the debug log device tracker, bound to the top level.
module dlt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);
    import dlt_pkg::*;

    // Only defined event kinds leave the block
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser <= KIND_NETTIME))
        else $error("undefined event kind");

    // Error, warning and reboot events carry a zero value
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_ERROR || m_tuser == KIND_WARN ||
                     m_tuser == KIND_REBOOT) |-> (m_tdata == 32'd0))
        else $error("nonzero value on a valueless event");

    // A tag event is always the only event of its byte
    a_tag_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_ERROR || m_tuser == KIND_WARN) |-> m_tlast)
        else $error("tag event not marked last");

    // A stalled event holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output transaction changed while stalled");

endmodule

bind debug_log_device_tracker dlt_checker u_dlt_checker (.*);
